// File: rtl/assert_macros.svh
// Assertion macros for the RTL, included by the sorter top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate-cycle implication, checked outside reset.
`define CHECK_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// Next-cycle implication, checked outside reset.
`define CHECK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`endif

// File: rtl/sis_pkg.sv
// Package for the stable insertion sorter: payload, control and state types.
package sis_pkg;

   // Input transaction payload
   typedef struct packed {
      logic [15:0] key_time;
      logic [7:0]  tag;
      logic        final_item;
   } req_type;

   // Result transaction payload
   typedef struct packed {
      logic [7:0]  out_tag;
      logic [15:0] out_time;
      logic        end_of_run;
      logic        overflowed;
   } rsp_type;

   // Per-cell control, driven by the top level
   typedef struct packed {
      logic ins_en;      // a record is being inserted this cycle
      logic drain_step;  // the chain shifts toward cell 0
      logic occupied;    // this cell holds a stored record
      logic at_fill;     // this cell is the first empty one
   } cell_ctrl_type;

   typedef enum logic {
      ST_FILL,
      ST_DRAIN
   } state_type;

endpackage

// File: rtl/sis_cell.sv
// One compare-and-shift cell of the sorting chain.
module sis_cell #(
   parameter int KEY_WIDTH = 16
) (
   input  logic                  clock,
   input  sis_pkg::cell_ctrl_type ctrl,
   input  logic                  gt_prev,
   input  logic [KEY_WIDTH-1:0]  prev_key,
   input  logic [7:0]            prev_tag,
   input  logic [KEY_WIDTH-1:0]  next_key,
   input  logic [7:0]            next_tag,
   input  logic [KEY_WIDTH-1:0]  new_key,
   input  logic [7:0]            new_tag,
   output logic [KEY_WIDTH-1:0]  key,
   output logic [7:0]            tag,
   output logic                  gt
);
   import sis_pkg::*;

   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic [7:0]           tag_ff, tag_in;

   // Strictly greater keeps equal keys ahead of the new record
   assign gt = ctrl.occupied && (key_ff > new_key);

   // Shift up from the lower neighbor, take the new record, or shift down
   always_comb begin
      key_in = key_ff;
      tag_in = tag_ff;
      if (ctrl.ins_en) begin
         if (gt_prev) begin
            key_in = prev_key;
            tag_in = prev_tag;
         end else if (gt || ctrl.at_fill) begin
            key_in = new_key;
            tag_in = new_tag;
         end
      end else if (ctrl.drain_step) begin
         key_in = next_key;
         tag_in = next_tag;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      tag_ff <= tag_in;
   end

   assign key = key_ff;
   assign tag = tag_ff;

endmodule

// File: rtl/stable_insertion_sorter_unit.sv
// Top level of the stable insertion sorter: cell chain, fill count and drain control.
//
// Usage:
//   req channel: one record per transaction (key_time, tag, final_item).
//   Records are inserted in ascending key order; a record goes behind every
//   stored record with an equal key. Insertion does not depend on the fill
//   level, since every cell compares against the broadcast key at once,
//   so records may arrive back to back.
//   A record with final_item set is inserted too unless the store is full;
//   from the next cycle the chain drains through rsp, one record per cycle
//   while rsp_stall is low, out of cell 0, the last one flagged end_of_run.
//   overflowed is set on every drained record if any record was dropped
//   because all CAPACITY cells were full. The first result appears in the
//   cycle after the final record is accepted.
//   req_stall is high for the whole drain.
//   rsp_stall freezes the chain; the shown result holds until taken.
//   Reset empties the store and clears the overflow flag.
module stable_insertion_sorter_unit #(
   parameter int CAPACITY  = 64,
   parameter int KEY_WIDTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sis_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sis_pkg::rsp_type rsp_data
);
   import sis_pkg::*;
`include "assert_macros.svh"

   localparam int CW = $clog2(CAPACITY + 1);

   state_type state_ff, state_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic          drop_ff, drop_in;

   logic req_acc, rsp_acc, full, ins_en;
   logic [KEY_WIDTH-1:0] new_key;

   logic [KEY_WIDTH-1:0] cell_key [CAPACITY];
   logic [7:0]           cell_tag [CAPACITY];
   logic [CAPACITY-1:0]  cell_gt;

   assign req_acc = req_valid && !req_stall;
   assign rsp_acc = rsp_valid && !rsp_stall;
   assign full    = (fill_ff == CW'(CAPACITY));
   assign ins_en  = req_acc && !full;
   assign new_key = KEY_WIDTH'(req_data.key_time);

   // Cell chain
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      cell_ctrl_type        ctrl;
      logic                 gt_prev;
      logic [KEY_WIDTH-1:0] prev_key, next_key;
      logic [7:0]           prev_tag, next_tag;

      assign ctrl.ins_en     = ins_en;
      assign ctrl.drain_step = rsp_acc;
      assign ctrl.occupied   = (CW'(i) < fill_ff);
      assign ctrl.at_fill    = (CW'(i) == fill_ff);

      if (i == 0) begin : g_first
         assign gt_prev  = 1'b0;
         assign prev_key = new_key;
         assign prev_tag = req_data.tag;
      end else begin : g_mid
         assign gt_prev  = cell_gt[i-1];
         assign prev_key = cell_key[i-1];
         assign prev_tag = cell_tag[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign next_key = '0;
         assign next_tag = '0;
      end else begin : g_inner
         assign next_key = cell_key[i+1];
         assign next_tag = cell_tag[i+1];
      end

      sis_cell #(
         .KEY_WIDTH(KEY_WIDTH)
      ) u_cell (
         .clock   (clock),
         .ctrl    (ctrl),
         .gt_prev (gt_prev),
         .prev_key(prev_key),
         .prev_tag(prev_tag),
         .next_key(next_key),
         .next_tag(next_tag),
         .new_key (new_key),
         .new_tag (req_data.tag),
         .key     (cell_key[i]),
         .tag     (cell_tag[i]),
         .gt      (cell_gt[i])
      );
   end

   // Fill and drain control
   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      drop_in  = drop_ff;
      case (state_ff)
         ST_FILL: begin
            if (req_acc) begin
               if (full) begin
                  drop_in = 1'b1;
               end else begin
                  fill_in = fill_ff + CW'(1);
               end
               if (req_data.final_item) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (rsp_acc) begin
               fill_in = fill_ff - CW'(1);
               if (fill_ff == CW'(1)) begin
                  state_in = ST_FILL;
                  drop_in  = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL;
         fill_ff  <= '0;
         drop_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         drop_ff  <= drop_in;
      end
   end

   // Result straight from cell 0, which is a register
   assign req_stall           = (state_ff == ST_DRAIN);
   assign rsp_valid           = (state_ff == ST_DRAIN);
   assign rsp_data.out_tag    = cell_tag[0];
   assign rsp_data.out_time   = 16'(cell_key[0]);
   assign rsp_data.end_of_run = (fill_ff == CW'(1));
   assign rsp_data.overflowed = drop_ff;

   // Checks
   `CHECK_NOW(a_drain_not_empty, clock, reset, state_ff == ST_DRAIN, fill_ff != '0)
   `CHECK_NOW(a_fill_bound, clock, reset, 1'b1, fill_ff <= CW'(CAPACITY))
   `CHECK_NOW(a_drop_only_full, clock, reset, drop_ff && state_ff == ST_FILL, full)
   `CHECK_NEXT(a_end_leaves_drain, clock, reset, rsp_acc && rsp_data.end_of_run,
               state_ff == ST_FILL && fill_ff == '0 && !drop_ff)

endmodule

// File: dv/tb_stable_insertion_sorter_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for the stable insertion sorter: insertion, stable ordering, drain, overflow.
module tb_stable_insertion_sorter_unit;
   import sis_pkg::*;

   localparam int STORE_DEPTH   = 64;
   localparam int KEY_BITS      = 16;
   localparam logic [15:0] KEY_MASK = 16'((32'd1 << KEY_BITS) - 1);
   localparam int TOTAL_ITEMS   = 430;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT   = 200000;

   typedef struct packed {
      logic [15:0] key;
      logic [7:0]  tag;
   } job_rec_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Golden copy of the sorted store and the drained records still owed
   job_rec_type sorted_jobs[$];
   logic        jobs_dropped = 1'b0;
   rsp_type     owed_results[$];

   int error_count   = 0;
   int items_sent    = 0;
   int results_seen  = 0;
   int sets_drained  = 0;
   int overflow_sets = 0;
   int cycle_count   = 0;
   bit idle_on       = 1'b1;

   stable_insertion_sorter_unit #(
      .CAPACITY (STORE_DEPTH),
      .KEY_WIDTH(KEY_BITS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t ns: timeout after %0d cycles, %0d results still owed",
               $time, cycle_count, owed_results.size());
      $display("Verification failed");
      $finish;
   end

   // Insert one accepted record into the golden store; on the final mark, queue the drain
   function automatic void predict_insert(input req_type rec);
      job_rec_type job;
      rsp_type     drained;
      int          pos;
      int          n;
      job.key = rec.key_time & KEY_MASK;
      job.tag = rec.tag;
      if (sorted_jobs.size() >= STORE_DEPTH) begin
         jobs_dropped = 1'b1;
      end else begin
         // stable: goes behind every stored record with an equal key
         pos = 0;
         while (pos < sorted_jobs.size() && sorted_jobs[pos].key <= job.key) pos++;
         sorted_jobs.insert(pos, job);
      end
      if (rec.final_item) begin
         n = sorted_jobs.size();
         for (int k = 0; k < n; k++) begin
            drained.out_tag    = sorted_jobs[k].tag;
            drained.out_time   = sorted_jobs[k].key;
            drained.end_of_run = (k == n - 1);
            drained.overflowed = jobs_dropped;
            owed_results.push_back(drained);
         end
         if (jobs_dropped) overflow_sets++;
         sets_drained++;
         sorted_jobs.delete();
         jobs_dropped = 1'b0;
      end
   endfunction

   function automatic void flag_field(input string name, input logic [15:0] expv,
                                      input logic [15:0] actv);
      if (actv !== expv) begin
         $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, expv, actv);
         error_count++;
      end
   endfunction

   // Result checker and random receiver stall
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (owed_results.size() == 0) begin
            $display("%0t ns: unexpected result, expected none, got %p", $time, rsp_data);
            error_count++;
         end else begin
            exp_rsp = owed_results.pop_front();
            flag_field("out_tag", 16'(exp_rsp.out_tag), 16'(rsp_data.out_tag));
            flag_field("out_time", exp_rsp.out_time, rsp_data.out_time);
            flag_field("end_of_run", 16'(exp_rsp.end_of_run), 16'(rsp_data.end_of_run));
            flag_field("overflowed", 16'(exp_rsp.overflowed), 16'(rsp_data.overflowed));
         end
      end
      rsp_stall <= idle_on && ($urandom_range(0, 99) < 19);
   end

   // One transaction on the request side, with an optional idle gap ahead of it
   // (the gap comes ahead of about one record in eight)
   task automatic send_record(input logic [15:0] key, input logic [7:0] tag,
                              input logic last);
      req_type rec;
      rec = '{key_time: key, tag: tag, final_item: last};
      if (idle_on && $urandom_range(0, 99) < 12) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= rec;
      do @(posedge clock); while (req_stall);
      predict_insert(rec);
      items_sent++;
   endtask

   // Hold off the sender until every owed result has been taken
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (owed_results.size() != 0) @(posedge clock);
   endtask

   // mode 0: dense duplicates, 1: full range, else near the key extremes
   function automatic logic [15:0] pick_key(input int mode);
      case (mode)
         0: return 16'($urandom_range(0, 7));
         1: return 16'($urandom);
         default: return $urandom_range(0, 1) ? 16'($urandom_range(0, 2))
                                              : 16'(16'hFFFF - $urandom_range(0, 2));
      endcase
   endfunction

   task automatic test_directed();
      logic [15:0] edge_keys[6]  = '{16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFE};
      logic [7:0]  edge_tags[6]  = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80};
      logic [15:0] tie_keys[6]   = '{16'd5, 16'd5, 16'd3, 16'd5, 16'd3, 16'd5};
      // single-record set drains right away
      send_record(16'h1234, 8'hA5, 1'b1);
      // key and tag extremes, arriving unsorted
      foreach (edge_keys[i]) send_record(edge_keys[i], edge_tags[i], i == 5);
      // equal keys keep their arrival order
      foreach (tie_keys[i]) send_record(tie_keys[i], 8'h41 + 8'(i), i == 5);
      // already ascending input
      for (int i = 0; i < 4; i++) send_record(16'(10 * (i + 1)), 8'h61 + 8'(i), i == 3);
   endtask

   // Exactly full, final record dropped on a full store, drops before the final
   task automatic test_capacity();
      int set_lens[3] = '{STORE_DEPTH, STORE_DEPTH + 1, STORE_DEPTH + 4};
      foreach (set_lens[s]) begin
         for (int i = 0; i < set_lens[s]; i++)
            send_record(pick_key(s % 2), 8'($urandom), i == set_lens[s] - 1);
         wait_for_drain();
      end
   endtask

   task automatic test_random_sets();
      int set_len;
      int set_mode;
      int set_idx;
      int pick;
      set_idx = 0;
      while (items_sent < TOTAL_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 70)      set_len = $urandom_range(1, 12);
         else if (pick < 95) set_len = $urandom_range(13, 40);
         else                set_len = $urandom_range(STORE_DEPTH - 4, STORE_DEPTH + 6);
         set_mode = $urandom_range(0, 2);
         // a run of sets with both sides at full rate
         idle_on = !(set_idx >= 6 && set_idx < 12);
         for (int i = 0; i < set_len; i++)
            send_record(pick_key(set_mode), 8'($urandom), i == set_len - 1);
         if ($urandom_range(0, 9) == 0) wait_for_drain();
         set_idx++;
      end
      idle_on = 1'b1;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      wait_for_drain();
      test_capacity();
      test_random_sets();
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d records in %0d sets, %0d of them overflowing the %0d-entry store;",
               items_sent, sets_drained, overflow_sets, STORE_DEPTH);
      $display("checked %0d sorted results, %0d errors", results_seen, error_count);
      if (error_count == 0 && owed_results.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl
rtl/sis_pkg.sv
rtl/sis_cell.sv
rtl/stable_insertion_sorter_unit.sv
dv/tb_stable_insertion_sorter_unit.sv
